// File: rtl/ttip_pkg.sv
package ttip_pkg;

  // Field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned END_W   = 16;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned WIDE_W  = VALUE_W + RADIX_W + 1;

  // Configuration
  localparam int unsigned MAX_LENGTH_DEF = 65535;
  localparam int unsigned APB_DATA_W     = 32;
  localparam int unsigned APB_ADDR_W     = 3;
  localparam logic [0:0]  REG_RADIX      = 1'b0;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  // Base limits and digit codes
  localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_ONE  = 6'd1;
  localparam logic [RADIX_W-1:0] BASE_MIN  = 6'd2;
  localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [RADIX_W-1:0] BASE_MAX  = 6'd36;
  localparam logic [RADIX_W-1:0] NOT_DIGIT = 6'd63;

  localparam logic [VALUE_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_B  = 8'h62;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_PREFIX,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  // Parse state apart from the position counters
  typedef struct packed {
    phase_e               phase;
    logic                 negative;
    logic [VALUE_W-1:0]   magnitude;
    logic [RADIX_W-1:0]   base;
    logic                 saturated;
    logic                 any_digit;
  } ttip_state_t;

  // One result request
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               overflow;
    logic [END_W-1:0]   end_position;
    logic               no_digits;
  } ttip_res_t;

  localparam ttip_state_t STATE_CLEAR = '{
    phase:     PH_SPACE,
    negative:  1'b0,
    magnitude: '0,
    base:      BASE_AUTO,
    saturated: 1'b0,
    any_digit: 1'b0
  };

  // Clamp the register value to a usable base; auto stays auto
  function automatic logic [RADIX_W-1:0] clamp_base(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] b;
    b = r;
    if (r == BASE_ONE) b = BASE_MIN;
    if (r > BASE_MAX) b = BASE_MAX;
    return b;
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Digit value of a character, NOT_DIGIT where it is none
  function automatic logic [RADIX_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] t;
    t = c;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      t = c - CH_ZERO;
    end else if ((c >= CH_LO_A) && (c <= CH_LO_Z)) begin
      t = c - CH_LO_A + 8'd10;
    end else if ((c >= CH_UP_A) && (c <= CH_UP_Z)) begin
      t = c - CH_UP_A + 8'd10;
    end else begin
      t = {2'b00, NOT_DIGIT};
    end
    return t[RADIX_W-1:0];
  endfunction

endpackage

// File: rtl/ttip_if.sv
interface ttip_req_if;
  logic                         valid;
  logic                         ready;
  logic [ttip_pkg::CHAR_W-1:0]  character;
  logic                         last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

interface ttip_res_if;
  logic                          valid;
  logic                          ready;
  logic [ttip_pkg::VALUE_W-1:0]  value;
  logic                          overflow;
  logic [ttip_pkg::END_W-1:0]    end_position;
  logic                          no_digits;

  modport source (output valid, output value, output overflow, output end_position,
                  output no_digits, input ready);
  modport sink   (input valid, input value, input overflow, input end_position,
                  input no_digits, output ready);
endinterface

// File: rtl/ttip_cfg.sv
module ttip_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ttip_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [ttip_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ttip_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [ttip_pkg::RADIX_W-1:0]      radix_o
);
  import ttip_pkg::*;

  logic [RADIX_W-1:0] radix_q;
  logic [RADIX_W-1:0] radix_d;
  logic               sel_radix;

  assign pready    = 1'b1;
  assign sel_radix = (paddr[APB_ADDR_W-1] == REG_RADIX);

  // Take a write in the access phase
  always_comb begin
    radix_d = radix_q;
    if (psel && penable && pwrite && pready && sel_radix) begin
      radix_d = pwdata[RADIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else begin
      radix_q <= radix_d;
    end
  end

  // Read back
  assign prdata  = sel_radix ? {{(APB_DATA_W-RADIX_W){1'b0}}, radix_q} : '0;
  assign radix_o = radix_q;

endmodule

// File: rtl/ttip_core.sv
module ttip_core #(
  parameter int unsigned MAX_LENGTH = ttip_pkg::MAX_LENGTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ttip_req_if.sink                      req_i,
  input  logic [ttip_pkg::RADIX_W-1:0]  radix_i,
  input  logic                          out_free_i,
  output logic                          res_load_o,
  output ttip_pkg::ttip_res_t           res_o
);
  import ttip_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_LENGTH + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_LENGTH);

  // Input register
  logic              s1_valid_q;
  logic [CHAR_W-1:0] s1_char_q;
  logic              s1_last_q;
  logic              advance;

  // Parse state
  ttip_state_t       st_q, st_c, st_d;
  logic [PosW-1:0]   pos_q, pos_c, pos_d;
  logic [PosW-1:0]   end_q, end_c, end_d;

  logic [CHAR_W-1:0]  lower;
  logic [RADIX_W-1:0] dig;
  logic [RADIX_W-1:0] base_v;
  logic [VALUE_W-1:0] lim;
  logic [WIDE_W-1:0]  wide;
  logic               start_num;
  logic               take_digit;

  assign advance     = s1_valid_q && (!s1_last_q || out_free_i);
  assign req_i.ready = !s1_valid_q || advance;
  assign res_load_o  = advance && s1_last_q;

  // Hold the request until the parse step takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      s1_char_q <= req_i.character;
      s1_last_q <= req_i.last;
    end
  end

  assign lower = s1_char_q | CASE_BIT;
  assign dig   = digit_of(s1_char_q);

  // Parse one character
  always_comb begin
    st_c       = st_q;
    pos_c      = pos_q;
    end_c      = end_q;
    start_num  = 1'b0;
    take_digit = 1'b0;
    base_v     = (pos_q == '0) ? clamp_base(radix_i) : st_q.base;
    lim        = st_q.negative ? NEG_LIMIT : POS_LIMIT;
    wide       = '0;
    if (advance && (pos_q < PosMax)) begin
      pos_c = pos_q + 1'b1;
      case (st_q.phase)
        PH_SPACE: begin
          if (!is_space(s1_char_q)) begin
            if ((s1_char_q == CH_MINUS) || (s1_char_q == CH_PLUS)) begin
              st_c.negative = (s1_char_q == CH_MINUS);
              st_c.phase    = PH_SIGNED;
            end else begin
              start_num = 1'b1;
            end
          end
        end
        PH_SIGNED: start_num = 1'b1;
        PH_ZERO: begin
          if (((base_v == BASE_AUTO) || (base_v == BASE_HEX)) && (lower == CH_LO_X)) begin
            base_v     = BASE_HEX;
            st_c.phase = PH_PREFIX;
          end else if (((base_v == BASE_AUTO) || (base_v == BASE_MIN))
                       && (lower == CH_LO_B)) begin
            base_v     = BASE_MIN;
            st_c.phase = PH_PREFIX;
          end else begin
            if (base_v == BASE_AUTO) base_v = BASE_OCT;
            take_digit = 1'b1;
          end
        end
        PH_PREFIX, PH_DIGITS: take_digit = 1'b1;
        default: ;
      endcase

      // Leading zero or first digit
      if (start_num) begin
        if (s1_char_q == CH_ZERO) begin
          st_c.any_digit = 1'b1;
          end_c          = pos_q + 1'b1;
          st_c.phase     = PH_ZERO;
        end else begin
          if (base_v == BASE_AUTO) base_v = BASE_DEC;
          take_digit = 1'b1;
        end
      end

      // Multiply-add, saturate past the signed limit
      wide = {{(WIDE_W-VALUE_W){1'b0}}, st_q.magnitude}
             * {{(WIDE_W-RADIX_W){1'b0}}, base_v}
             + {{(WIDE_W-RADIX_W){1'b0}}, dig};
      if (take_digit) begin
        if (dig < base_v) begin
          if (!st_q.saturated) begin
            if (wide > {{(WIDE_W-VALUE_W){1'b0}}, lim}) begin
              st_c.saturated = 1'b1;
            end else begin
              st_c.magnitude = wide[VALUE_W-1:0];
            end
          end
          st_c.any_digit = 1'b1;
          end_c          = pos_q + 1'b1;
          st_c.phase     = PH_DIGITS;
        end else begin
          st_c.phase = PH_DONE;
        end
      end
      st_c.base = base_v;
    end
  end

  // Form the result on the last character
  always_comb begin
    if (st_c.saturated) begin
      res_o.value = st_c.negative ? NEG_LIMIT : POS_LIMIT;
    end else begin
      res_o.value = st_c.negative ? (VALUE_W'(0) - st_c.magnitude) : st_c.magnitude;
    end
    res_o.overflow     = st_c.saturated;
    res_o.end_position = st_c.any_digit ? END_W'(end_c) : '0;
    res_o.no_digits    = !st_c.any_digit;
  end

  // Restart after the result
  always_comb begin
    st_d  = st_c;
    pos_d = pos_c;
    end_d = end_c;
    if (res_load_o) begin
      st_d  = STATE_CLEAR;
      pos_d = '0;
      end_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= STATE_CLEAR;
      pos_q <= '0;
      end_q <= '0;
    end else begin
      st_q  <= st_d;
      pos_q <= pos_d;
      end_q <= end_d;
    end
  end

  a_no_digit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o && res_o.no_digits |-> (res_o.value == '0) && (res_o.end_position == '0))
    else $error("result without digits carries a value or position");

  a_ovf_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o && res_o.overflow |-> (res_o.value == POS_LIMIT) || (res_o.value == NEG_LIMIT))
    else $error("overflow result not saturated");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o |=> (pos_q == '0) && (st_q.phase == PH_SPACE) && !st_q.saturated)
    else $error("parse state not cleared after result");

  a_end_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q <= PosMax) && (end_q <= pos_q))
    else $error("position counters out of range");

endmodule

// File: rtl/ttip_out.sv
module ttip_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_load_i,
  input  ttip_pkg::ttip_res_t  res_i,
  output logic                 out_free_o,
  ttip_res_if.source           res_o
);
  import ttip_pkg::*;

  logic      valid_q;
  logic      valid_d;
  ttip_res_t res_q;

  assign out_free_o = !valid_q || res_o.ready;

  // Hold the result until it is taken
  always_comb begin
    valid_d = valid_q;
    if (res_load_i) begin
      valid_d = 1'b1;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.value        = res_q.value;
  assign res_o.overflow     = res_q.overflow;
  assign res_o.end_position = res_q.end_position;
  assign res_o.no_digits    = res_q.no_digits;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_i |-> out_free_o)
    else $error("result loaded over one still waiting");

endmodule

// File: rtl/text_to_integer_parser.sv
// Channel   Direction  Payload                                        Handshake
// req_i     in         character[7:0], last                           valid/ready
// res_o     out        value[63:0], overflow, end_position[15:0],
//                      no_digits                                      valid/ready
// apb       in/out     psel penable pwrite paddr[2:0] pwdata prdata   pready high
//
// One character is accepted every cycle unless a last character waits for the
// output register; the parse state loop, a 64x6 multiply-add and signed-limit
// compare, sets that figure. Results reach res_o through the output register.
// Reset clears the parse state and sets radix to 10; no clearing pass is needed.
// A stalled result is held in the output register while later characters of the
// next string keep flowing; only a second last character waits for it.
module text_to_integer_parser #(
  parameter int unsigned MAX_LENGTH = ttip_pkg::MAX_LENGTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ttip_req_if.sink                          req_i,
  ttip_res_if.source                        res_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ttip_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [ttip_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ttip_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import ttip_pkg::*;

  logic [RADIX_W-1:0] radix;
  logic               out_free;
  logic               res_load;
  ttip_res_t          res;

  ttip_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .radix_o (radix)
  );

  ttip_core #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .radix_i    (radix),
    .out_free_i (out_free),
    .res_load_o (res_load),
    .res_o      (res)
  );

  ttip_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_load_i (res_load),
    .res_i      (res),
    .out_free_o (out_free),
    .res_o      (res_o)
  );

endmodule

// File: tb/sv/tb_text_to_integer_parser.sv
module tb_text_to_integer_parser;
  import ttip_pkg::*;

  localparam int unsigned IDLE_PCT     = 14;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned STEADY_PHASE = 3;
  localparam int unsigned HOLD_PHASE   = 6;
  localparam int unsigned RANDOM_PHASE = 9;
  localparam int unsigned MAX_PRINTS   = 40;
  localparam logic [CHAR_W-1:0]     CH_NUL     = 8'h00;
  localparam logic [APB_ADDR_W-1:0] RADIX_ADDR = APB_ADDR_W'({REG_RADIX, 2'b00});

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              lst;
  } char_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  ttip_req_if req_if ();
  ttip_res_if res_if ();

  // Stimulus and expectation stores
  char_t       feed_q[$];
  logic [7:0]  word_q[$];
  ttip_res_t   results_due[$];
  char_t       next_char;
  bit          char_taken = 1'b0;
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count = 0;

  // Predicted parse state
  logic [RADIX_W-1:0] radix_reg = RADIX_RESET;
  phase_e             parse_phase = PH_SPACE;
  logic               neg = 1'b0;
  logic [VALUE_W-1:0] mag = '0;
  logic [RADIX_W-1:0] cur_base = BASE_AUTO;
  logic               sat = 1'b0;
  int unsigned        char_pos = 0;
  int unsigned        end_at = 0;
  logic               seen_digit = 1'b0;

  logic [RADIX_W-1:0] radix_plan [PHASES] = '{
    6'd0, 6'd16, 6'd2, 6'd1, 6'd8, 6'd36, 6'd63, 6'd37, 6'd3, 6'd0, 6'd10, 6'd0
  };

  text_to_integer_parser u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [RADIX_W-1:0] fold_radix(input logic [RADIX_W-1:0] r);
    if (r == BASE_ONE) return BASE_MIN;
    if (r > BASE_MAX) return BASE_MAX;
    return r;
  endfunction

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [RADIX_W-1:0] char_digit(input logic [CHAR_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return RADIX_W'(c - CH_ZERO);
    if (c >= CH_LO_A && c <= CH_LO_Z) return RADIX_W'(c - CH_LO_A + 8'd10);
    if (c >= CH_UP_A && c <= CH_UP_Z) return RADIX_W'(c - CH_UP_A + 8'd10);
    return NOT_DIGIT;
  endfunction

  function automatic void clear_parse();
    parse_phase = PH_SPACE;
    neg         = 1'b0;
    mag         = '0;
    cur_base    = BASE_AUTO;
    sat         = 1'b0;
    char_pos    = 0;
    end_at      = 0;
    seen_digit  = 1'b0;
  endfunction

  // Accumulate one digit; freeze the magnitude once the limit is passed
  function automatic void take_digit(input logic [RADIX_W-1:0] d, input int unsigned p);
    logic [VALUE_W-1:0] lim;
    lim = neg ? NEG_LIMIT : POS_LIMIT;
    if (!sat) begin
      if (mag > (lim - VALUE_W'(d)) / VALUE_W'(cur_base)) sat = 1'b1;
      else mag = mag * VALUE_W'(cur_base) + VALUE_W'(d);
    end
    seen_digit  = 1'b1;
    end_at      = p + 1;
    parse_phase = PH_DIGITS;
  endfunction

  function automatic void digit_or_stop(input logic [CHAR_W-1:0] c, input int unsigned p);
    logic [RADIX_W-1:0] d;
    d = char_digit(c);
    if (d < cur_base) take_digit(d, p);
    else parse_phase = PH_DONE;
  endfunction

  function automatic void begin_number(input logic [CHAR_W-1:0] c, input int unsigned p);
    if (c == CH_ZERO) begin
      seen_digit  = 1'b1;
      end_at      = p + 1;
      parse_phase = PH_ZERO;
    end else begin
      if (cur_base == BASE_AUTO) cur_base = BASE_DEC;
      digit_or_stop(c, p);
    end
  endfunction

  // Advance the parse by one accepted character; queue a result on the last one
  function automatic void parse_char(input logic [CHAR_W-1:0] c, input logic lst);
    ttip_res_t res;
    if (char_pos < MAX_LENGTH_DEF) begin
      if (char_pos == 0) cur_base = fold_radix(radix_reg);
      case (parse_phase)
        PH_SPACE: begin
          if (!is_blank(c)) begin
            if (c == CH_MINUS || c == CH_PLUS) begin
              neg         = (c == CH_MINUS);
              parse_phase = PH_SIGNED;
            end else begin
              begin_number(c, char_pos);
            end
          end
        end
        PH_SIGNED: begin_number(c, char_pos);
        PH_ZERO: begin
          if ((cur_base == BASE_AUTO || cur_base == BASE_HEX) && (c | CASE_BIT) == CH_LO_X) begin
            cur_base    = BASE_HEX;
            parse_phase = PH_PREFIX;
          end else if ((cur_base == BASE_AUTO || cur_base == BASE_MIN) &&
                       (c | CASE_BIT) == CH_LO_B) begin
            cur_base    = BASE_MIN;
            parse_phase = PH_PREFIX;
          end else begin
            if (cur_base == BASE_AUTO) cur_base = BASE_OCT;
            digit_or_stop(c, char_pos);
          end
        end
        PH_PREFIX, PH_DIGITS: digit_or_stop(c, char_pos);
        default: ;
      endcase
      char_pos++;
    end
    if (lst) begin
      if (sat) res.value = neg ? NEG_LIMIT : POS_LIMIT;
      else res.value = neg ? (VALUE_W'(0) - mag) : mag;
      res.overflow     = sat;
      res.end_position = seen_digit ? END_W'(end_at) : '0;
      res.no_digits    = !seen_digit;
      results_due.push_back(res);
      clear_parse();
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    if (error_count < MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic check_result();
    ttip_res_t want;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("result with none pending, value %0h", res_if.value));
      return;
    end
    want = results_due.pop_front();
    if (res_if.value !== want.value)
      report_mismatch($sformatf("value %0h, expected %0h", res_if.value, want.value));
    if (res_if.overflow !== want.overflow)
      report_mismatch($sformatf("overflow %0b, expected %0b", res_if.overflow, want.overflow));
    if (res_if.end_position !== want.end_position)
      report_mismatch($sformatf("end_position %0d, expected %0d",
                                res_if.end_position, want.end_position));
    if (res_if.no_digits !== want.no_digits)
      report_mismatch($sformatf("no_digits %0b, expected %0b",
                                res_if.no_digits, want.no_digits));
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk_i) begin
    char_taken <= rst_ni && req_if.valid && req_if.ready;
    if (rst_ni && req_if.valid && req_if.ready) parse_char(req_if.character, req_if.last);
    if (rst_ni && res_if.valid && res_if.ready) check_result();
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // ---------------------------------------------------------------- drivers

  // Present the next request once the current one is taken; idle at random
  always @(negedge clk_i) begin
    if (rst_ni && (!req_if.valid || char_taken)) begin
      if (feed_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        next_char = feed_q.pop_front();
        req_if.valid     <= 1'b1;
        req_if.character <= next_char.ch;
        req_if.last      <= next_char.lst;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Drop ready at random, and once for a long hold to back up the block
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        res_if.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_left    <= HOLD_CYCLES;
        hold_done    <= 1'b1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Write the radix, then read it back
  task automatic set_radix(input logic [RADIX_W-1:0] r);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RADIX_ADDR;
    pwdata  <= APB_DATA_W'(r);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    radix_reg = r;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DATA_W'(r))
      report_mismatch($sformatf("radix read %0h, expected %0h", prdata, r));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold until every request is taken and every result is back, then settle
  task automatic drain();
    while (feed_q.size() != 0 || req_if.valid || results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic [CHAR_W-1:0] digit_char(input int unsigned d);
    if (d < 10) return CH_ZERO + CHAR_W'(d);
    return ($urandom_range(1) ? CH_LO_A : CH_UP_A) + CHAR_W'(d - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] blank_char();
    if ($urandom_range(5) == 0) return CH_TAB + CHAR_W'($urandom_range(4));
    return CH_SPACE;
  endfunction

  function automatic logic [CHAR_W-1:0] any_case(input logic [CHAR_W-1:0] c);
    return $urandom_range(1) ? c : (c & ~CASE_BIT);
  endfunction

  task automatic add_sign();
    int unsigned pick;
    pick = $urandom_range(2);
    if (pick == 1) word_q.push_back(CH_PLUS);
    else if (pick == 2) word_q.push_back(CH_MINUS);
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) word_q.push_back(s[i]);
  endtask

  task automatic add_number(input logic [VALUE_W-1:0] v, input int unsigned b);
    logic [CHAR_W-1:0] digs[$];
    do begin
      digs.push_front(digit_char(int'(v % VALUE_W'(b))));
      v = v / VALUE_W'(b);
    end while (v != 0);
    foreach (digs[i]) word_q.push_back(digs[i]);
  endtask

  // Move the built string to the feed, marking its final byte
  task automatic send_word();
    foreach (word_q[i]) feed_q.push_back('{ch: word_q[i], lst: (i == word_q.size() - 1)});
    word_q.delete();
  endtask

  task automatic queue_text(input string s);
    add_text(s);
    send_word();
  endtask

  // One random string: mostly well formed, some near the limits, some noise
  task automatic queue_random_string();
    int unsigned b, pick, form, n;
    logic [VALUE_W-1:0] v;
    b    = fold_radix(radix_reg);
    pick = $urandom_range(99);
    if (pick < 55) begin
      repeat ($urandom_range(3)) word_q.push_back(blank_char());
      add_sign();
      if (b == BASE_AUTO) begin
        form = $urandom_range(3);
        if (form == 0) begin
          word_q.push_back(CH_ZERO);
          word_q.push_back(any_case(CH_LO_X));
          b = BASE_HEX;
        end else if (form == 1) begin
          word_q.push_back(CH_ZERO);
          word_q.push_back(any_case(CH_LO_B));
          b = BASE_MIN;
        end else if (form == 2) begin
          word_q.push_back(CH_ZERO);
          b = BASE_OCT;
        end else begin
          word_q.push_back(digit_char($urandom_range(1, 9)));
          b = BASE_DEC;
        end
      end else if ((b == BASE_HEX || b == BASE_MIN) && $urandom_range(1)) begin
        word_q.push_back(CH_ZERO);
        word_q.push_back(any_case(b == BASE_HEX ? CH_LO_X : CH_LO_B));
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
      repeat (n) word_q.push_back(digit_char($urandom_range(b - 1)));
      repeat ($urandom_range(2)) word_q.push_back(CHAR_W'($urandom_range(255)));
    end else if (pick < 70) begin
      // signed extremes and their neighbours
      add_sign();
      if (b == BASE_AUTO) begin
        if ($urandom_range(1)) begin
          word_q.push_back(CH_ZERO);
          word_q.push_back(any_case(CH_LO_X));
          b = BASE_HEX;
        end else begin
          b = BASE_DEC;
        end
      end
      form = $urandom_range(3);
      if (form == 0) v = POS_LIMIT;
      else if (form == 1) v = NEG_LIMIT;
      else if (form == 2) v = NEG_LIMIT + 1;
      else v = {$urandom, $urandom};
      add_number(v, b);
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 8)) word_q.push_back(CHAR_W'($urandom_range(255)));
    end else begin
      // broken fragments: lone signs, bare prefixes, stray blanks
      repeat ($urandom_range(1, 6)) begin
        form = $urandom_range(6);
        if (form == 0) word_q.push_back(blank_char());
        else if (form == 1) word_q.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
        else if (form == 2) word_q.push_back(CH_ZERO);
        else if (form == 3) word_q.push_back(any_case(CH_LO_X));
        else if (form == 4) word_q.push_back(any_case(CH_LO_B));
        else if (form == 5) word_q.push_back(digit_char($urandom_range(35)));
        else word_q.push_back(CHAR_W'($urandom_range(255)));
      end
    end
    send_word();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [RADIX_W-1:0] r;
    req_if.valid     = 1'b0;
    req_if.character = '0;
    req_if.last      = 1'b0;
    res_if.ready     = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni  = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed strings at the reset radix
    queue_text(" +42");
    queue_text("-");
    word_q.push_back(CH_NUL);
    send_word();
    queue_text("\t-0x");
    queue_text("z9");
    drain();

    // Directed prefixes with auto-detected base
    set_radix(BASE_AUTO);
    queue_text("0x");
    queue_text("0b1");
    queue_text("017");
    queue_text("0X1F");
    drain();

    // Random phases over a spread of radix settings
    for (int k = 0; k < PHASES; k++) begin
      r = (k == RANDOM_PHASE) ? RADIX_W'($urandom_range(63)) : radix_plan[k];
      set_radix(r);
      steady   = (k == STEADY_PHASE);
      hold_req = (k == HOLD_PHASE);
      while (feed_q.size() < PHASE_ITEMS) queue_random_string();
      drain();
      steady = 1'b0;
    end

    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
rtl/ttip_pkg.sv
rtl/ttip_if.sv
rtl/ttip_cfg.sv
rtl/ttip_core.sv
rtl/ttip_out.sv
rtl/text_to_integer_parser.sv
tb/sv/tb_text_to_integer_parser.sv
